// File: sv/lfu_pkg.sv
// Shared constants and controller/datapath interface types for the LFU cache.
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int STAMP_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} lfu_cmd_t;

	typedef struct packed {
		logic last;
		logic empty;
		logic out_free;
	} lfu_status_t;

endpackage

// File: sv/lfu_cache_lru_tiebreak.sv
// Top level of the LFU cache with least-recently-used tie break.
// A request's result becomes valid after the scan over the occ stored entries (no scan when
// empty), where occ is the number of stored entries, at most ENTRIES. A request is taken only
// when the sequencer is idle, and its commit waits while an earlier result is still stalled;
// the scan reads the entry memories one entry a cycle.
// Reset clears the sequencer, fill count, stamp counter and result valid flag and sets the
// capacity to 16; entry memories are not cleared, the fill count marks which entries hold data.
module lfu_cache_lru_tiebreak #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic signed [lfu_pkg::KEY_W-1:0]  req_key,
	input  logic signed [lfu_pkg::DATA_W-1:0] req_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic signed [lfu_pkg::DATA_W-1:0] read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);
	import lfu_pkg::*;

	lfu_cmd_t    cmd;
	lfu_status_t status;

	assign cfg_ready = 1'b1;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lfu_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.func        (func),
		.req_key     (req_key),
		.req_value   (req_value),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	// A request is never taken while an earlier one is still being worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted back to back");

	// A get hit never evicts, and a put never reports a hit.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && evicted))
		else $error("result reports both hit and eviction");

	a_read_zero_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> read_value == '0)
		else $error("nonzero read value without a hit");

	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> evicted_key == '0)
		else $error("nonzero evicted key without eviction");

endmodule

// File: sv/lfu_ctrl.sv
// Sequencer for the LFU cache: accepts a request, runs the entry scan, commits.
module lfu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lfu_pkg::lfu_status_t status,
	output lfu_pkg::lfu_cmd_t    cmd
);
	import lfu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.step   = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_FINISH) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= status.empty ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/lfu_dp.sv
// Datapath of the LFU cache: entry memories, serial scan, victim search, result register.
module lfu_dp #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [lfu_pkg::CAP_W-1:0]  cfg_data,
	input  logic                       func,
	input  logic [lfu_pkg::KEY_W-1:0]  req_key,
	input  logic [lfu_pkg::DATA_W-1:0] req_value,
	input  lfu_pkg::lfu_cmd_t          cmd,
	output lfu_pkg::lfu_status_t       status,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [lfu_pkg::DATA_W-1:0] read_value,
	output logic                       evicted,
	output logic [lfu_pkg::KEY_W-1:0]  evicted_key
);
	import lfu_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW    = (CAP_W > OCC_W) ? CAP_W : OCC_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [KEY_W-1:0]      key_mem   [ENTRIES];
	logic [DATA_W-1:0]     data_mem  [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem   [ENTRIES];
	logic [STAMP_W-1:0]    stamp_mem [ENTRIES];

	logic [CAP_W-1:0]   cap_q;
	logic [OCC_W-1:0]   occ_q;
	logic [STAMP_W-1:0] stamp_ctr_q;

	logic               func_q;
	logic [KEY_W-1:0]   key_q;
	logic [DATA_W-1:0]  value_q;
	logic [IDX_W-1:0]   idx_q;

	logic                  rd_v_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [KEY_W-1:0]      rd_key_s1;
	logic [DATA_W-1:0]     rd_data_s1;
	logic [COUNT_BITS-1:0] rd_cnt_s1;
	logic [STAMP_W-1:0]    rd_stamp_s1;

	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [DATA_W-1:0]     hit_data_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;

	logic                  best_v_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [KEY_W-1:0]      best_key_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [STAMP_W-1:0]    best_stamp_q;

	logic                  out_valid_q;
	logic                  found_q;
	logic [DATA_W-1:0]     read_value_q;
	logic                  evicted_q;
	logic [KEY_W-1:0]      evicted_key_q;

	logic [CW-1:0]         cap_eff;
	logic                  is_put, get_hit, put_ok, put_hit, ins, full, touch;
	logic                  better;
	logic [IDX_W-1:0]      wr_idx;
	logic [COUNT_BITS-1:0] cnt_new;

	assign cap_eff = (CW'(cap_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_q);
	assign is_put  = (func_q == FUNC_PUT);
	assign get_hit = !is_put && hit_q;
	assign put_ok  = is_put && (cap_eff != '0);
	assign put_hit = put_ok && hit_q;
	assign ins     = put_ok && !hit_q;
	assign full    = CW'(occ_q) >= cap_eff;
	assign touch   = get_hit || put_hit || ins;

	// Valid entries always form the prefix below the fill count, so a victim
	// slot is refilled in place and a fresh slot sits right at the count.
	assign wr_idx  = hit_q ? hit_idx_q : (full ? best_idx_q : IDX_W'(occ_q));
	assign cnt_new = ins ? COUNT_BITS'(1) :
	                 ((hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1);

	assign better = (rd_cnt_s1 < best_cnt_q) ||
	                ((rd_cnt_s1 == best_cnt_q) && (rd_stamp_s1 < best_stamp_q));

	assign status.last     = (OCC_W'(idx_q) + 1'b1) == occ_q;
	assign status.empty    = (occ_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_key_s1   <= key_mem[idx_q];
			rd_data_s1  <= data_mem[idx_q];
			rd_cnt_s1   <= cnt_mem[idx_q];
			rd_stamp_s1 <= stamp_mem[idx_q];
			rd_idx_s1   <= idx_q;
		end
		if (cmd.commit && ins) begin
			key_mem[wr_idx] <= key_q;
		end
		if (cmd.commit && put_ok) begin
			data_mem[wr_idx] <= value_q;
		end
		if (cmd.commit && touch) begin
			cnt_mem[wr_idx]   <= cnt_new;
			stamp_mem[wr_idx] <= stamp_ctr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q  <= func;
			key_q   <= req_key;
			value_q <= req_value;
		end
		if (rd_v_s1 && (rd_key_s1 == key_q)) begin
			hit_idx_q  <= rd_idx_s1;
			hit_data_q <= rd_data_s1;
			hit_cnt_q  <= rd_cnt_s1;
		end
		if (rd_v_s1 && (!best_v_q || better)) begin
			best_idx_q   <= rd_idx_s1;
			best_key_q   <= rd_key_s1;
			best_cnt_q   <= rd_cnt_s1;
			best_stamp_q <= rd_stamp_s1;
		end
		if (cmd.commit) begin
			found_q       <= get_hit;
			read_value_q  <= get_hit ? hit_data_q : '0;
			evicted_q     <= ins && full;
			evicted_key_q <= (ins && full) ? best_key_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			stamp_ctr_q <= '0;
			idx_q       <= '0;
			rd_v_s1     <= 1'b0;
			hit_q       <= 1'b0;
			best_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			rd_v_s1 <= cmd.step;
			if (cmd.start) begin
				idx_q    <= '0;
				hit_q    <= 1'b0;
				best_v_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_v_s1) begin
				best_v_q <= 1'b1;
				if (rd_key_s1 == key_q) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (touch) begin
					stamp_ctr_q <= stamp_ctr_q + 1'b1;
				end
				if (ins && !full) begin
					occ_q <= occ_q + 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
